// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the window controller RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("window controller check failed");

// Check a property on every rising clock edge, reset included.
`define TWC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("window controller check failed");

`endif

// ===== rtl/core/twc_pkg.sv =====
// Shared types and constants of the window controller.
// Depends on nothing; imported by every module of the block.
package twc_pkg;

  localparam int unsigned SEQ_W    = 32;  // sequence field width
  localparam int unsigned WIN_W    = 7;   // window and threshold width
  localparam int unsigned Q_DEPTH  = 4;   // front to back queue depth
  localparam int unsigned Q_AW     = 2;   // queue pointer width
  localparam int unsigned Q_CW     = 3;   // queue fill count width

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);
  localparam logic [WIN_W-1:0] THRESH_RESET = WIN_W'(8);

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_ACK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // One classified request: a burst of count results starting at seq.
  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  seq;
    logic              mark;
    logic [WIN_W-1:0]  count;
    logic [WIN_W-1:0]  window;
    logic [WIN_W-1:0]  threshold;
    logic              avoidance;
    logic              round_done;
    logic              ignored;
  } job_t;

endpackage

// ===== rtl/core/twc_front.sv =====
// Front end: accepts requests, keeps the congestion state, classifies each request.
// Depends on twc_pkg and assert_macros.svh; feeds twc_queue.
`include "assert_macros.svh"

module twc_front #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned SEQ_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [twc_pkg::SEQ_W-1:0]   ack_number_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        full_i,
  output logic                        push_o,
  output twc_pkg::job_t               job_o
);
  import twc_pkg::*;

  localparam logic [WIN_W:0] MaxWin = (WIN_W+1)'(MAX_WINDOW);

  logic                inject_q;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [WIN_W-1:0]    thr_q, thr_d;
  logic [SEQ_BITS-1:0] next_seq_q, next_seq_d;
  logic [SEQ_BITS-1:0] held_ack_q, held_ack_d;
  logic                prev_valid_q, prev_valid_d;
  logic [1:0]          dup_q, dup_d;
  logic [WIN_W-1:0]    acks_q, acks_d;
  logic                open_q, open_d;

  logic                accept;
  logic [SEQ_BITS-1:0] ack_m;
  logic [WIN_W-1:0]    acks_inc;
  logic [1:0]          dup_inc;
  logic                dup_hit;
  logic [WIN_W:0]      grow_w;

  assign accept      = in_valid_i && !full_i;
  assign in_stall_o  = full_i;
  assign push_o      = accept;
  assign cfg_ready_o = 1'b1;

  assign ack_m    = ack_number_i[SEQ_BITS-1:0];
  assign acks_inc = acks_q + WIN_W'(1);
  assign dup_inc  = dup_q + 2'd1;
  assign dup_hit  = prev_valid_q && (ack_m == held_ack_q);

  // Double below threshold, else add one; saturate at the window limit
  always_comb begin
    if (win_q < thr_q) begin
      grow_w = {win_q, 1'b0};
    end else begin
      grow_w = {1'b0, win_q} + (WIN_W+1)'(1);
    end
    if (grow_w > MaxWin) begin
      grow_w = MaxWin;
    end
  end

  // Classify the request and compute the next state
  always_comb begin
    win_d        = win_q;
    thr_d        = thr_q;
    next_seq_d   = next_seq_q;
    held_ack_d   = held_ack_q;
    prev_valid_d = prev_valid_q;
    dup_d        = dup_q;
    acks_d       = acks_q;
    open_d       = open_q;

    job_o            = '0;
    job_o.kind       = KIND_STATUS;
    job_o.count      = WIN_W'(1);
    job_o.seq        = SEQ_W'(next_seq_q);

    if (accept) begin
      case (op_e'(operation_i))
        OP_SEND: begin
          open_d       = 1'b1;
          acks_d       = '0;
          prev_valid_d = 1'b0;
          dup_d        = '0;
          job_o.kind   = KIND_DATA;
          job_o.count  = win_q;
          job_o.mark   = inject_q && (win_q > thr_q);
        end
        OP_ACK: begin
          if (!open_q) begin
            job_o.ignored = 1'b1;
          end else begin
            acks_d = acks_inc;
            if (dup_hit && (dup_inc >= 2'd2)) begin
              // third identical ack: retransmit and collapse the window
              thr_d            = win_q >> 1;
              win_d            = WINDOW_RESET;
              next_seq_d       = ack_m;
              open_d           = 1'b0;
              dup_d            = '0;
              job_o.kind       = KIND_RETX;
              job_o.seq        = SEQ_W'(ack_m);
              job_o.round_done = 1'b1;
            end else begin
              if (dup_hit) begin
                dup_d = dup_inc;
              end else begin
                held_ack_d   = ack_m;
                prev_valid_d = 1'b1;
                dup_d        = '0;
              end
              if (acks_inc >= win_q) begin
                // round complete: grow the window
                win_d            = grow_w[WIN_W-1:0];
                next_seq_d       = ack_m;
                open_d           = 1'b0;
                job_o.seq        = SEQ_W'(ack_m);
                job_o.round_done = 1'b1;
              end
            end
          end
        end
        default: begin
          job_o.ignored = 1'b0;
        end
      endcase
    end

    job_o.window    = win_d;
    job_o.threshold = thr_d;
    job_o.avoidance = (win_d >= thr_d);
  end

  // Hold the loss-injection register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inject_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      inject_q <= cfg_data_i;
    end
  end

  // Advance the congestion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= WINDOW_RESET;
      thr_q        <= THRESH_RESET;
      next_seq_q   <= '0;
      held_ack_q   <= '0;
      prev_valid_q <= 1'b0;
      dup_q        <= '0;
      acks_q       <= '0;
      open_q       <= 1'b0;
    end else begin
      win_q        <= win_d;
      thr_q        <= thr_d;
      next_seq_q   <= next_seq_d;
      held_ack_q   <= held_ack_d;
      prev_valid_q <= prev_valid_d;
      dup_q        <= dup_d;
      acks_q       <= acks_d;
      open_q       <= open_d;
    end
  end

  `TWC_ASSERT(a_win_range, clk_i, rst_ni, (win_q >= WINDOW_RESET) && ({1'b0, win_q} <= MaxWin))
  `TWC_ASSERT(a_open_acks, clk_i, rst_ni, open_q |-> (acks_q < win_q))
  `TWC_ASSERT(a_retx_win, clk_i, rst_ni, push_o && job_o.kind == KIND_RETX |=> win_q == 1)

endmodule

// ===== rtl/core/twc_queue.sv =====
// Short queue of classified requests between front and back end.
// Depends on twc_pkg.
module twc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  twc_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output twc_pkg::job_t  job_o,
  output logic           empty_o
);
  import twc_pkg::*;

  job_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CW'(1);
        2'b01:   cnt_q <= cnt_q - Q_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/twc_back.sv =====
// Back end: expands queued requests into registered results, one per cycle unless stalled.
// Depends on twc_pkg and assert_macros.svh; drains twc_queue.
`include "assert_macros.svh"

module twc_back #(
  parameter int unsigned SEQ_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  twc_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [twc_pkg::SEQ_W-1:0]  seq_number_o,
  output logic                       loss_mark_o,
  output logic                       last_o,
  output logic [twc_pkg::WIN_W-1:0]  window_o,
  output logic [twc_pkg::WIN_W-1:0]  threshold_o,
  output logic                       avoidance_o,
  output logic                       round_done_o,
  output logic                       ignored_o
);
  import twc_pkg::*;

  job_t                cur_q;
  logic                cur_valid_q;
  logic [WIN_W-1:0]    k_q;

  logic                out_valid_q;
  logic [1:0]          kind_q;
  logic [SEQ_W-1:0]    seq_q;
  logic                loss_q;
  logic                last_q;
  logic [WIN_W-1:0]    win_q;
  logic [WIN_W-1:0]    thr_q;
  logic                avoid_q;
  logic                done_q;
  logic                ign_q;

  logic                out_adv;
  logic                emit;
  logic                seg_last;
  logic [SEQ_BITS-1:0] seg_seq;

  assign out_adv  = !out_valid_q || !out_stall_i;
  assign emit     = cur_valid_q && out_adv;
  assign seg_last = ((k_q + WIN_W'(1)) == cur_q.count);
  assign seg_seq  = cur_q.seq[SEQ_BITS-1:0] + SEQ_BITS'(k_q);
  assign pop_o    = !empty_i && (!cur_valid_q || (emit && seg_last));

  // Load the next request or step through the current burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      k_q         <= '0;
    end else if (emit) begin
      cur_valid_q <= !seg_last;
      k_q         <= k_q + WIN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= cur_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= cur_q.kind;
      seq_q   <= SEQ_W'(seg_seq);
      loss_q  <= cur_q.mark && (k_q == '0);
      last_q  <= seg_last;
      win_q   <= cur_q.window;
      thr_q   <= cur_q.threshold;
      avoid_q <= cur_q.avoidance;
      done_q  <= cur_q.round_done;
      ign_q   <= cur_q.ignored;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign seq_number_o = seq_q;
  assign loss_mark_o  = loss_q;
  assign last_o       = last_q;
  assign window_o     = win_q;
  assign threshold_o  = thr_q;
  assign avoidance_o  = avoid_q;
  assign round_done_o = done_q;
  assign ignored_o    = ign_q;

  `TWC_ASSERT(a_k_range, clk_i, rst_ni, cur_valid_q |-> (k_q < cur_q.count))
  `TWC_ASSERT(a_pop_avail, clk_i, rst_ni, pop_o |-> !empty_i)
  `TWC_ASSERT(a_burst_open, clk_i, rst_ni, (out_valid_q && !last_q) |-> cur_valid_q)

endmodule

// ===== rtl/core/tahoe_window_controller.sv =====
// Tahoe congestion window controller, top level.
// Depends on twc_pkg, twc_front, twc_queue and twc_back.
//
// The block takes one request per cycle on the input channel while its
// four-entry queue has room. A send request yields as many data results as
// the current window (1 to MAX_WINDOW), an ack request yields one result;
// results leave one per cycle from the back end's output register while the
// output is not stalled. A request passes through the queue, the back end's
// current-request register and the output register; earlier requests still
// draining add their results ahead of it. All window, threshold and sequence
// state is updated in the front end at acceptance, so acks may follow a send
// immediately. The single configuration register (inject_loss, reset 1) is
// always ready; the user must write it only while the block idles, which the
// block itself does not enforce.
module tahoe_window_controller #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned SEQ_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [twc_pkg::SEQ_W-1:0]  ack_number_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [twc_pkg::SEQ_W-1:0]  seq_number_o,
  output logic                       loss_mark_o,
  output logic                       last_o,
  output logic [twc_pkg::WIN_W-1:0]  window_o,
  output logic [twc_pkg::WIN_W-1:0]  threshold_o,
  output logic                       avoidance_o,
  output logic                       round_done_o,
  output logic                       ignored_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i
);
  import twc_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t job_in;
  job_t job_out;

  twc_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .ack_number_i (ack_number_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  twc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  twc_back #(
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .seq_number_o (seq_number_o),
    .loss_mark_o  (loss_mark_o),
    .last_o       (last_o),
    .window_o     (window_o),
    .threshold_o  (threshold_o),
    .avoidance_o  (avoidance_o),
    .round_done_o (round_done_o),
    .ignored_o    (ignored_o)
  );

endmodule
